// ----- rtl/core/crc_pkg.sv -----
// ----------------------------------------------------------------------------
// crc_pkg
// Shared types and constants for the root counter timer block.
// ----------------------------------------------------------------------------
`default_nettype none

package crc_pkg;

   // Clamp on elapsed cycles per tick request
   localparam int MAX_CYCLES = 1023;

   localparam int DATA_W  = 16;
   localparam int CYC_W   = 10;
   localparam int ACC_W   = 11;
   // accumulator plus clamped cycles, also the widest tick count
   localparam int SUM_W   = $clog2((1 << ACC_W) + MAX_CYCLES);
   localparam int NUM_TMR = 3;

   // Request commands
   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   // Address window
   localparam logic [31:0] WIN_BASE = 32'h1F80_1100;
   localparam logic [31:0] WIN_LAST = 32'h1F80_1128;

   // Register offsets inside a slot
   localparam logic [3:0] OFF_COUNT  = 4'h0;
   localparam logic [3:0] OFF_MODE   = 4'h4;
   localparam logic [3:0] OFF_TARGET = 4'h8;

   localparam logic [DATA_W-1:0] TOP_VALUE = 16'hFFFF;
   localparam int SLOW_SHIFT = 3;   // divide by 8

   // Mode word bits
   localparam int MB_RESET_AT_TARGET = 3;
   localparam int MB_IRQ_TARGET      = 4;
   localparam int MB_IRQ_TOP         = 5;
   localparam int MB_SRC_LO          = 8;
   localparam int MB_REACHED_TARGET  = 11;
   localparam int MB_REACHED_TOP     = 12;

   typedef struct packed {
      logic [1:0]        command;
      logic [31:0]       address;
      logic [DATA_W-1:0] write_value;
      logic [CYC_W-1:0]  cycles;
   } crc_req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              status;
      logic              irq_raised;
   } crc_rsp_type;

   typedef struct packed {
      logic exec;     // carry out the accepted request
      logic step;     // advance timer 2 by one tick
      logic finish;   // load the tick result into the response register
   } crc_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic ticks_done;
   } crc_stat_type;

endpackage

`default_nettype wire

// ----- rtl/core/crc_ctrl.sv -----
// ----------------------------------------------------------------------------
// crc_ctrl
// Sequencer: accepts requests, runs tick loops, owns the response valid.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire crc_pkg::crc_stat_type stat,
   output crc_pkg::crc_cmd_type       cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_STEP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      cmd          = '0;
      req_stall    = 1'b1;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            req_stall = !out_free;
            if (req_valid && out_free) begin
               cmd.exec = 1'b1;
               if (stat.is_tick) begin
                  state_in = ST_STEP;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_STEP: begin
            if (!stat.ticks_done) begin
               cmd.step = 1'b1;
            end else if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_tick_enters_step: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && stat.is_tick |=> state_ff == ST_STEP)
      else $error("tick request did not start the step loop");

   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past((cmd.exec && !stat.is_tick) || cmd.finish))
      else $error("response valid rose without a result load");

   a_step_only_pending: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> state_ff == ST_STEP && !stat.ticks_done)
      else $error("step issued with no ticks pending");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STEP |-> req_stall && !cmd.exec)
      else $error("request taken during tick loop");

endmodule

`default_nettype wire

// ----- rtl/core/crc_dp.sv -----
// ----------------------------------------------------------------------------
// crc_dp
// Timer registers, bus decode, tick counter and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire crc_pkg::crc_req_type req_payload,
   input  wire crc_pkg::crc_cmd_type cmd,
   output crc_pkg::crc_stat_type     stat,
   output crc_pkg::crc_rsp_type      rsp_payload
);

   localparam int DW = crc_pkg::DATA_W;
   localparam int SW = crc_pkg::SUM_W;

   logic [DW-1:0] count_ff  [crc_pkg::NUM_TMR];
   logic [DW-1:0] mode_ff   [crc_pkg::NUM_TMR];
   logic [DW-1:0] target_ff [crc_pkg::NUM_TMR];
   logic [crc_pkg::ACC_W-1:0] accum_ff, accum_in;
   logic [SW-1:0] ticks_ff, ticks_in;
   logic          irq_ff;
   crc_pkg::crc_rsp_type rsp_ff;

   // decode
   logic          mapped;
   logic [1:0]    slot;
   logic [3:0]    offset;
   logic [DW-1:0] rd_value;

   // tick setup
   logic [SW-1:0] cyc_sat;
   logic [SW-1:0] acc_sum;
   logic          slow_src;

   // one tick of timer 2
   logic [DW-1:0] c1, c2, c3;
   logic [DW-1:0] m1, m2;
   logic          hit_target, hit_top, step_irq;

   always_comb begin
      slot   = req_payload.address[5:4];
      offset = req_payload.address[3:0];
      mapped = (req_payload.address[31:6] == crc_pkg::WIN_BASE[31:6])
            && (req_payload.address[5:0] <= crc_pkg::WIN_LAST[5:0])
            && (offset == crc_pkg::OFF_COUNT || offset == crc_pkg::OFF_MODE
                || offset == crc_pkg::OFF_TARGET);
      rd_value = '0;
      if (mapped) begin
         case (offset)
            crc_pkg::OFF_COUNT:  rd_value = count_ff[slot];
            crc_pkg::OFF_MODE:   rd_value = mode_ff[slot];
            crc_pkg::OFF_TARGET: rd_value = target_ff[slot];
            default:             rd_value = '0;
         endcase
      end
   end

   always_comb begin
      if (SW'(req_payload.cycles) > SW'(crc_pkg::MAX_CYCLES)) begin
         cyc_sat = SW'(crc_pkg::MAX_CYCLES);
      end else begin
         cyc_sat = SW'(req_payload.cycles);
      end
      acc_sum  = SW'(accum_ff) + cyc_sat;
      slow_src = mode_ff[2][crc_pkg::MB_SRC_LO + 1];   // source 2 or 3
      if (slow_src) begin
         ticks_in = acc_sum >> crc_pkg::SLOW_SHIFT;
         accum_in = crc_pkg::ACC_W'(acc_sum[crc_pkg::SLOW_SHIFT-1:0]);
      end else begin
         ticks_in = acc_sum;
         accum_in = '0;
      end
   end

   // target compare first, then the top value on the possibly reset count
   always_comb begin
      c1         = count_ff[2] + DW'(1);
      hit_target = (c1 == target_ff[2]);
      m1         = mode_ff[2];
      c2         = c1;
      if (hit_target) begin
         m1[crc_pkg::MB_REACHED_TARGET] = 1'b1;
         if (mode_ff[2][crc_pkg::MB_RESET_AT_TARGET]) begin
            c2 = '0;
         end
      end
      hit_top = (c2 == crc_pkg::TOP_VALUE);
      m2      = m1;
      c3      = c2;
      if (hit_top) begin
         m2[crc_pkg::MB_REACHED_TOP] = 1'b1;
         if (!mode_ff[2][crc_pkg::MB_RESET_AT_TARGET]) begin
            c3 = '0;
         end
      end
      step_irq = (hit_target && mode_ff[2][crc_pkg::MB_IRQ_TARGET])
              || (hit_top && mode_ff[2][crc_pkg::MB_IRQ_TOP]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < crc_pkg::NUM_TMR; i++) begin
            count_ff[i]  <= '0;
            mode_ff[i]   <= '0;
            target_ff[i] <= '0;
         end
         accum_ff <= '0;
         ticks_ff <= '0;
         irq_ff   <= 1'b0;
      end else begin
         if (cmd.exec) begin
            case (req_payload.command)
               crc_pkg::CMD_WRITE: begin
                  if (mapped) begin
                     case (offset)
                        crc_pkg::OFF_COUNT:  count_ff[slot]  <= req_payload.write_value;
                        crc_pkg::OFF_MODE:   mode_ff[slot]   <= req_payload.write_value;
                        crc_pkg::OFF_TARGET: target_ff[slot] <= req_payload.write_value;
                        default: ;
                     endcase
                  end
               end
               crc_pkg::CMD_TICK: begin
                  accum_ff <= accum_in;
                  ticks_ff <= ticks_in;
                  irq_ff   <= 1'b0;
               end
               default: ;
            endcase
         end
         if (cmd.step) begin
            count_ff[2] <= c3;
            mode_ff[2]  <= m2;
            ticks_ff    <= ticks_ff - SW'(1);
            irq_ff      <= irq_ff | step_irq;
         end
      end
   end

   // response register, no reset needed
   always_ff @(posedge clock) begin
      if (cmd.exec && req_payload.command != crc_pkg::CMD_TICK) begin
         rsp_ff.read_data  <= (req_payload.command == crc_pkg::CMD_READ) ? rd_value : '0;
         rsp_ff.status     <= (req_payload.command == crc_pkg::CMD_WRITE) && !mapped;
         rsp_ff.irq_raised <= 1'b0;
      end else if (cmd.finish) begin
         rsp_ff.read_data  <= '0;
         rsp_ff.status     <= 1'b0;
         rsp_ff.irq_raised <= irq_ff;
      end
   end

   assign rsp_payload     = rsp_ff;
   assign stat.is_tick    = (req_payload.command == crc_pkg::CMD_TICK);
   assign stat.ticks_done = (ticks_ff == '0);

   a_step_counts_down: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> ticks_ff == $past(ticks_ff) - SW'(1))
      else $error("tick counter did not decrement on a step");

   a_irq_sticky: assert property (@(posedge clock) disable iff (reset)
      cmd.step && irq_ff |=> irq_ff)
      else $error("interrupt flag dropped during tick loop");

   a_tick_clears_irq: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && stat.is_tick |=> !irq_ff)
      else $error("interrupt flag not cleared at tick start");

endmodule

`default_nettype wire

// ----- rtl/core/console_root_counter_timers.sv -----
// Reads and writes give their registered response in the cycle after acceptance.
// A tick request steps once for each timer tick it produces (up to about 1030);
// timer 2 advances one tick per cycle in the datapath.
// One read or write per cycle while rsp_stall is low; requests wait on tick loops.
// Reset: synchronous, active high; all timer registers and the accumulator clear.
// ----------------------------------------------------------------------------
// console_root_counter_timers
// Three 16-bit root counters on a bus window with a cycle-driven timer 2.
// ----------------------------------------------------------------------------
`default_nettype none

module console_root_counter_timers (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire crc_pkg::crc_req_type req_payload,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output crc_pkg::crc_rsp_type      rsp_payload
);

   crc_pkg::crc_cmd_type  cmd;
   crc_pkg::crc_stat_type stat;

   crc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   crc_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
